/* rtl/core/cils_pkg.sv */
// Package for the C integer literal scanner: radix and kind codes,
// character constants and small character helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cils_pkg;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_INTEGER = 2'd1,
      KIND_FLOAT   = 2'd2
   } kind_type;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UL    = 8'h4C;
   localparam logic [7:0] CH_UU    = 8'h55;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   // Fold lower-case letters onto upper case
   function automatic logic [7:0] upper_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LA && c <= CH_LZ) begin
         r = c - CASE_GAP;
      end
      return r;
   endfunction

   // Hex digit value of a character, NO_DIGIT when it is none
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] r;
      r = NO_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
         r = {1'b0, c[3:0]} + 5'd9;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/c_integer_literal_scanner.sv */
// C integer literal scanner: one character per beat, one result beat per token.
// An accepted character enters the input register; a token's last character
// then loads the result register. One character per cycle while req_stall is
// low. Synchronous active-high reset clears the token state and both valid
// flags. Loop: radix shift-add on the 64-bit accumulator. Depends on cils_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c_integer_literal_scanner (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_ch,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output cils_pkg::kind_type       rsp_kind,
   output logic [63:0]              rsp_value,
   output cils_pkg::radix_type      rsp_radix_code,
   output logic                     rsp_signed_flag,
   output logic [1:0]               rsp_long_count,
   output logic [1:0]               rsp_unsigned_count
);
   import cils_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;

   // token state
   logic [1:0]  position_ff, position_in;
   radix_type   radix_ff, radix_in;
   logic [63:0] accum_ff, accum_in;
   logic        in_suffix_ff, in_suffix_in;
   logic        suffix_bad_ff, suffix_bad_in;
   logic [1:0]  l_seen_ff, l_seen_in;
   logic [1:0]  u_seen_ff, u_seen_in;
   logic        saw_x_ff, saw_x_in;
   logic        floating_ff, floating_in;
   logic        hex_seen_ff, hex_seen_in;

   // result register
   logic        rsp_valid_ff;
   kind_type    kind_ff, kind_in;
   logic [63:0] value_ff, value_in;
   radix_type   radix_out_ff, radix_out_in;
   logic        signed_ff, signed_in;
   logic [1:0]  long_ff, long_in;
   logic [1:0]  unsigned_ff, unsigned_in;

   logic        consume;
   logic        accept;
   logic [7:0]  up;
   logic [4:0]  dig;
   logic [67:0] product;
   logic [67:0] acc_sum;
   logic [63:0] acc_next;
   logic [4:0]  base;
   logic        bad;

   // A character without last never touches the result register
   assign consume   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   assign up  = upper_ascii(in_ch_ff);
   assign dig = digit_value(in_ch_ff);

   // Shift-add in the current radix, saturate when bits spill past 64
   always_comb begin
      case (radix_ff)
         RADIX_HEX: begin
            product = {accum_ff, 4'b0000};
            base    = 5'd16;
         end
         RADIX_OCT: begin
            product = {1'b0, accum_ff, 3'b000};
            base    = 5'd8;
         end
         default: begin
            product = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0};
            base    = 5'd10;
         end
      endcase
      acc_sum  = product + {64'd0, dig[3:0]};
      acc_next = (acc_sum[67:64] != 4'd0) ? '1 : acc_sum[63:0];
   end

   // Next token state and result for the character in the input register
   always_comb begin
      position_in   = position_ff;
      radix_in      = radix_ff;
      accum_in      = accum_ff;
      in_suffix_in  = in_suffix_ff;
      suffix_bad_in = suffix_bad_ff;
      l_seen_in     = l_seen_ff;
      u_seen_in     = u_seen_ff;
      saw_x_in      = saw_x_ff || (up == CH_UX);
      floating_in   = floating_ff || (in_ch_ff == CH_DOT) ||
                      (up == CH_UE && !saw_x_ff);
      hex_seen_in   = hex_seen_ff;

      if (in_suffix_ff) begin
         if (!suffix_bad_ff) begin
            if (up == CH_UL) begin
               if (l_seen_ff != 2'd3) l_seen_in = l_seen_ff + 2'd1;
            end else if (up == CH_UU) begin
               if (u_seen_ff != 2'd3) u_seen_in = u_seen_ff + 2'd1;
            end else begin
               suffix_bad_in = 1'b1;
            end
         end
      end else if (position_ff == 2'd0) begin
         if (in_ch_ff == CH_ZERO) begin
            radix_in = RADIX_OCT;
            accum_in = '0;
         end else if (dig < 5'd10) begin
            radix_in = RADIX_DEC;
            accum_in = {60'd0, dig[3:0]};
         end else begin
            // no leading digit: everything is suffix
            radix_in     = RADIX_DEC;
            in_suffix_in = 1'b1;
            if (up == CH_UL) begin
               l_seen_in = 2'd1;
            end else if (up == CH_UU) begin
               u_seen_in = 2'd1;
            end else begin
               suffix_bad_in = 1'b1;
            end
         end
      end else if (position_ff == 2'd1 && radix_ff == RADIX_OCT && up == CH_UX) begin
         radix_in    = RADIX_HEX;
         hex_seen_in = 1'b0;
      end else if (radix_ff == RADIX_HEX && !hex_seen_ff) begin
         if (dig < 5'd16) begin
            accum_in    = acc_next;
            hex_seen_in = 1'b1;
         end else begin
            in_suffix_in  = 1'b1;
            suffix_bad_in = 1'b1;
         end
      end else if (dig < base) begin
         accum_in    = acc_next;
         hex_seen_in = 1'b1;
      end else begin
         in_suffix_in = 1'b1;
         if (!suffix_bad_ff) begin
            if (up == CH_UL) begin
               if (l_seen_ff != 2'd3) l_seen_in = l_seen_ff + 2'd1;
            end else if (up == CH_UU) begin
               if (u_seen_ff != 2'd3) u_seen_in = u_seen_ff + 2'd1;
            end else begin
               suffix_bad_in = 1'b1;
            end
         end
      end

      if (position_ff != 2'd2) position_in = position_ff + 2'd1;

      // Build the result from the updated token state
      bad = suffix_bad_in || (l_seen_in == 2'd3) || (u_seen_in > 2'd1) ||
            (radix_in == RADIX_HEX && !hex_seen_in);
      if (floating_in) begin
         kind_in      = KIND_FLOAT;
         value_in     = '0;
         radix_out_in = RADIX_DEC;
         signed_in    = 1'b0;
         long_in      = 2'd0;
         unsigned_in  = 2'd0;
      end else begin
         kind_in      = bad ? KIND_INVALID : KIND_INTEGER;
         value_in     = accum_in;
         radix_out_in = radix_in;
         signed_in    = (u_seen_in == 2'd0);
         long_in      = l_seen_in;
         unsigned_in  = u_seen_in;
      end
   end

   // Hold the input beat until it is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
      if (accept) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
   end

   // Advance the token state; clear it after the last character
   always_ff @(posedge clock) begin
      if (reset || (consume && in_last_ff)) begin
         position_ff   <= 2'd0;
         radix_ff      <= RADIX_DEC;
         accum_ff      <= '0;
         in_suffix_ff  <= 1'b0;
         suffix_bad_ff <= 1'b0;
         l_seen_ff     <= 2'd0;
         u_seen_ff     <= 2'd0;
         saw_x_ff      <= 1'b0;
         floating_ff   <= 1'b0;
         hex_seen_ff   <= 1'b0;
      end else if (consume) begin
         position_ff   <= position_in;
         radix_ff      <= radix_in;
         accum_ff      <= accum_in;
         in_suffix_ff  <= in_suffix_in;
         suffix_bad_ff <= suffix_bad_in;
         l_seen_ff     <= l_seen_in;
         u_seen_ff     <= u_seen_in;
         saw_x_ff      <= saw_x_in;
         floating_ff   <= floating_in;
         hex_seen_ff   <= hex_seen_in;
      end
   end

   // Load the result beat on the last character, drop it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (consume && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (consume && in_last_ff) begin
         kind_ff      <= kind_in;
         value_ff     <= value_in;
         radix_out_ff <= radix_out_in;
         signed_ff    <= signed_in;
         long_ff      <= long_in;
         unsigned_ff  <= unsigned_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_value          = value_ff;
   assign rsp_radix_code     = radix_out_ff;
   assign rsp_signed_flag    = signed_ff;
   assign rsp_long_count     = long_ff;
   assign rsp_unsigned_count = unsigned_ff;

endmodule

`default_nettype wire
